>>> rtl/core/mltbp_pkg.sv
package mltbp_pkg;

  localparam int BUCKETS    = 1024;
  localparam int IDX_W      = $clog2(BUCKETS);
  localparam int TOK_W      = 16;
  localparam int TIME_W     = 32;
  localparam int PROD_W     = TIME_W + TOK_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int MEM_W      = 1 + TOK_W + TIME_W;
  localparam int RETRY_W    = 10;
  localparam int CNT_W      = $clog2(RETRY_W + 1);
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int LVL_W      = 2;

  localparam logic [RETRY_W-1:0]   MS_PER_SEC = RETRY_W'(1000);
  localparam logic [TOK_W-1:0]     CAP_RESET  = TOK_W'(1000);
  localparam logic [TOK_W-1:0]     RATE_RESET = TOK_W'(10);
  localparam logic [LVL_W-1:0]     LVL_USER   = LVL_W'(0);
  localparam logic [LVL_W-1:0]     LVL_ADDR   = LVL_W'(1);
  localparam logic [LVL_W-1:0]     LVL_LAST   = LVL_W'(2);

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REFILL_RATE = CFG_IDX_W'(1);

  typedef struct packed {
    logic [IDX_W-1:0]  user_bucket;
    logic [IDX_W-1:0]  address_bucket;
    logic [IDX_W-1:0]  endpoint_bucket;
    logic [TIME_W-1:0] now_seconds;
  } in_t;

  typedef struct packed {
    logic               allowed;
    logic [TOK_W-1:0]   remaining;
    logic [RETRY_W-1:0] retry_after_ms;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [TOK_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [RETRY_W-1:0] quot;
  } div_rsp_t;

endpackage

>>> rtl/core/mltbp_div.sv
module mltbp_div import mltbp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic               zero_r, zero_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TOK_W-1:0]   rem_r, rem_nxt;
  logic [RETRY_W-1:0] q_r, q_nxt;
  logic [TOK_W-1:0]   dvs_r, dvs_nxt;
  logic [TOK_W:0]     trial;
  logic               fits;

  // Restoring division of the constant 1000, one quotient bit per cycle.
  assign trial = {rem_r, q_r[RETRY_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    zero_nxt = zero_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      zero_nxt = (req.divisor == '0);
      cnt_nxt  = CNT_W'(RETRY_W);
      rem_nxt  = '0;
      q_nxt    = MS_PER_SEC;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? TOK_W'(trial - {1'b0, dvs_r}) : trial[TOK_W-1:0];
      q_nxt   = {q_r[RETRY_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    zero_r <= zero_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = zero_r ? MS_PER_SEC : q_r;

endmodule

>>> rtl/core/multi_level_token_bucket_policer.sv
// Channel  Ports                           Direction  Accepted when
// in       in_valid, in_ready, in_data     input      in_valid && in_ready
// out      out_valid, out_ready, out_data  output     out_valid && out_ready
// cfg      cfg_we, cfg_index, cfg_wdata    input      cfg_we
//
// One item at a time: each level steps through the read, data, multiply and update
// states on the bucket table, and the verdict is then formed in the finish state.
// A denial ends the walk and also waits for the serial divider that forms the retry time.
// After reset a clearing pass walks all 1024 table entries before items are taken.
// The result sits in an output register; the next item may be accepted while it waits.
module multi_level_token_bucket_policer import mltbp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_DAT  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  clr_r, clr_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  in_t               item_r, item_nxt;
  logic [TOK_W-1:0]  cap_r, cap_nxt;
  logic [TOK_W-1:0]  rate_r, rate_nxt;
  logic [TOK_W-1:0]  tok_r, tok_nxt;
  logic [TIME_W-1:0] stamp_r, stamp_nxt;
  logic              fresh_r, fresh_nxt;
  logic [TIME_W-1:0] elapsed_r, elapsed_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [TOK_W-1:0]  least_r, least_nxt;
  logic              allow_r, allow_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  logic [MEM_W-1:0]  mem [BUCKETS];
  logic [MEM_W-1:0]  rd_q_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [MEM_W-1:0]  mem_wdata;
  logic [IDX_W-1:0]  cur_idx;

  logic              word_valid;
  logic [TOK_W-1:0]  word_tok;
  logic [TIME_W-1:0] word_stamp;
  logic [SUM_W-1:0]  sum;
  logic [TOK_W-1:0]  clamp;
  logic              changed;
  logic              grant;
  logic [TOK_W-1:0]  tok_new;
  logic [TIME_W-1:0] stamp_new;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  mltbp_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    case (lvl_r)
      LVL_USER: cur_idx = item_r.user_bucket;
      LVL_ADDR: cur_idx = item_r.address_bucket;
      default:  cur_idx = item_r.endpoint_bucket;
    endcase
  end

  assign word_valid = rd_q_r[MEM_W-1];
  assign word_tok   = rd_q_r[TIME_W +: TOK_W];
  assign word_stamp = rd_q_r[TIME_W-1:0];

  // Refill, clamp at capacity, then try to take one token.
  assign sum       = {1'b0, prod_r} + SUM_W'(tok_r);
  assign clamp     = (sum > SUM_W'(cap_r)) ? cap_r : sum[TOK_W-1:0];
  assign changed   = fresh_r || (clamp != tok_r);
  assign grant     = (clamp != '0);
  assign tok_new   = grant ? (clamp - TOK_W'(1)) : clamp;
  assign stamp_new = changed ? item_r.now_seconds : stamp_r;

  assign mem_we    = (state_r == ST_CLR) || (state_r == ST_UPD);
  assign mem_waddr = (state_r == ST_CLR) ? clr_r : cur_idx;
  assign mem_wdata = (state_r == ST_CLR) ? '0 : {1'b1, tok_new, stamp_new};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q_r <= mem[cur_idx];
  end

  assign div_req.start   = (state_r == ST_UPD) && !grant;
  assign div_req.divisor = rate_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    lvl_nxt       = lvl_r;
    item_nxt      = item_r;
    cap_nxt       = cap_r;
    rate_nxt      = rate_r;
    tok_nxt       = tok_r;
    stamp_nxt     = stamp_r;
    fresh_nxt     = fresh_r;
    elapsed_nxt   = elapsed_r;
    prod_nxt      = prod_r;
    least_nxt     = least_r;
    allow_nxt     = allow_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY:    cap_nxt  = cfg_wdata;
        CFG_REFILL_RATE: rate_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLR: begin
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == {IDX_W{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          lvl_nxt   = LVL_USER;
          least_nxt = {TOK_W{1'b1}};
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_DAT;
      end
      ST_DAT: begin
        // A bucket seen for the first time starts full, stamped with the current time.
        fresh_nxt = !word_valid;
        if (word_valid) begin
          tok_nxt     = word_tok;
          stamp_nxt   = word_stamp;
          elapsed_nxt = (item_r.now_seconds > word_stamp) ?
                        (item_r.now_seconds - word_stamp) : '0;
        end else begin
          tok_nxt     = cap_r;
          stamp_nxt   = item_r.now_seconds;
          elapsed_nxt = '0;
        end
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(elapsed_r) * PROD_W'(rate_r);
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (grant) begin
          if (tok_new < least_r) begin
            least_nxt = tok_new;
          end
          if (lvl_r == LVL_LAST) begin
            allow_nxt = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            lvl_nxt   = lvl_r + LVL_W'(1);
            state_nxt = ST_RD;
          end
        end else begin
          allow_nxt = 1'b0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_nxt.allowed        = allow_r;
          out_nxt.remaining      = allow_r ? least_r : '0;
          out_nxt.retry_after_ms = allow_r ? '0 : div_rsp.quot;
          state_nxt              = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      lvl_r       <= LVL_USER;
      cap_r       <= CAP_RESET;
      rate_r      <= RATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      lvl_r       <= lvl_nxt;
      cap_r       <= cap_nxt;
      rate_r      <= rate_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r    <= item_nxt;
    tok_r     <= tok_nxt;
    stamp_r   <= stamp_nxt;
    fresh_r   <= fresh_nxt;
    elapsed_r <= elapsed_nxt;
    prod_r    <= prod_nxt;
    least_r   <= least_nxt;
    allow_r   <= allow_nxt;
    out_r     <= out_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> !in_ready)
    else $error("item taken during the clearing pass");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && state_r != ST_CLR) |-> (lvl_r <= LVL_LAST))
    else $error("level counter beyond the last level");

  a_grant_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.allowed) |-> (out_data.retry_after_ms == '0))
    else $error("granted item carries a retry time");

  a_deny_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.allowed) |-> (out_data.remaining == '0))
    else $error("denied item reports remaining tokens");

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_RD && lvl_r == LVL_USER))
    else $error("accepted item did not start at the first level");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import mltbp_pkg::*;

  typedef struct packed {
    logic             set_cfg;
    logic [TOK_W-1:0] cap;
    logic [TOK_W-1:0] rate;
    in_t              req;
    logic             pinned;
    out_t             want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_CAPACITY;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow copy of the bucket table and the limits, as the policer should hold them.
  logic              bkt_live   [BUCKETS];
  logic [TOK_W-1:0]  bkt_tokens [BUCKETS];
  logic [TIME_W-1:0] bkt_stamp  [BUCKETS];
  logic [TOK_W-1:0]  cap_reg = CAP_RESET;
  logic [TOK_W-1:0]  rate_reg = RATE_RESET;

  out_t              verdicts_due [$];
  row_t              directed [$];
  int                bad_verdicts = 0;
  logic              in_burst = 1'b0;
  logic              out_burst = 1'b0;
  int                out_hold = 0;
  logic [TIME_W-1:0] clock_s = '0;
  logic [IDX_W-1:0]  hot_base = '0;

  int phase_cap  [11] = '{1000, 1, 65535, 4, 20, 0, 7, 65535, 2, 50, 0};
  int phase_rate [11] = '{10, 1, 65535, 1, 3, 9, 0, 1, 65535, 2, 0};

  multi_level_token_bucket_policer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Walks the three levels in order; the first empty bucket ends the request.
  function automatic out_t police_request(in_t req);
    logic [IDX_W-1:0]  lvl_idx [3];
    logic [IDX_W-1:0]  b;
    logic [TOK_W-1:0]  least;
    logic [TIME_W-1:0] elapsed;
    logic [63:0]       total;
    out_t              res;
    lvl_idx[0] = req.user_bucket;
    lvl_idx[1] = req.address_bucket;
    lvl_idx[2] = req.endpoint_bucket;
    least = '1;
    for (int l = 0; l < 3; l++) begin
      b = lvl_idx[l];
      if (!bkt_live[b]) begin
        bkt_live[b]   = 1'b1;
        bkt_tokens[b] = cap_reg;
        bkt_stamp[b]  = req.now_seconds;
      end
      elapsed = (req.now_seconds > bkt_stamp[b]) ? req.now_seconds - bkt_stamp[b] : '0;
      total = 64'(bkt_tokens[b]) + 64'(elapsed) * 64'(rate_reg);
      if (total > 64'(cap_reg)) total = 64'(cap_reg);
      if (total != 64'(bkt_tokens[b])) begin
        bkt_tokens[b] = total[TOK_W-1:0];
        bkt_stamp[b]  = req.now_seconds;
      end
      if (bkt_tokens[b] == '0) begin
        res.allowed   = 1'b0;
        res.remaining = '0;
        res.retry_after_ms = (rate_reg == '0) ? MS_PER_SEC
                                              : RETRY_W'(32'(MS_PER_SEC) / 32'(rate_reg));
        return res;
      end
      bkt_tokens[b] = bkt_tokens[b] - 1'b1;
      if (bkt_tokens[b] < least) least = bkt_tokens[b];
    end
    res.allowed        = 1'b1;
    res.remaining      = least;
    res.retry_after_ms = '0;
    return res;
  endfunction

  // Mostly a handful of hot buckets so that they run dry, with some spread and extremes.
  function automatic logic [IDX_W-1:0] draw_bucket();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return hot_base + IDX_W'($urandom_range(0, 5));
    if (pick < 85) return IDX_W'($urandom);
    return ($urandom_range(0, 1) != 0) ? IDX_W'(BUCKETS - 1) : IDX_W'(0);
  endfunction

  function automatic in_t draw_request();
    in_t req;
    int  pick;
    pick = $urandom_range(0, 99);
    if (pick >= 97) begin
      clock_s = $urandom;
    end else if (pick >= 92) begin
      clock_s = clock_s + $urandom_range(4, 200);
    end else if (pick >= 85) begin
      clock_s = clock_s - $urandom_range(1, 5);
    end else if (pick >= 60) begin
      clock_s = clock_s + $urandom_range(1, 3);
    end
    req.now_seconds     = clock_s;
    req.user_bucket     = draw_bucket();
    req.address_bucket  = ($urandom_range(0, 9) == 0) ? req.user_bucket : draw_bucket();
    req.endpoint_bucket = ($urandom_range(0, 9) == 0) ? req.address_bucket : draw_bucket();
    return req;
  endfunction

  task automatic add_row(input logic set_cfg, input int cap, input int rate,
                         input int u, input int a, input int e, input logic [TIME_W-1:0] t,
                         input logic pinned, input int ok, input int rem, input int retry);
    row_t r;
    r.set_cfg                = set_cfg;
    r.cap                    = TOK_W'(cap);
    r.rate                   = TOK_W'(rate);
    r.req.user_bucket        = IDX_W'(u);
    r.req.address_bucket     = IDX_W'(a);
    r.req.endpoint_bucket    = IDX_W'(e);
    r.req.now_seconds        = t;
    r.pinned                 = pinned;
    r.want.allowed           = ok[0];
    r.want.remaining         = TOK_W'(rem);
    r.want.retry_after_ms    = RETRY_W'(retry);
    directed.push_back(r);
  endtask

  // Limits change only with the policer drained.
  task automatic set_limits(input logic [TOK_W-1:0] cap, input logic [TOK_W-1:0] rate);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CAPACITY;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_index <= CFG_REFILL_RATE;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cap_reg  = cap;
    rate_reg = rate;
  endtask

  // The verdict is queued before acceptance; no result can come out ahead of its item.
  task automatic send_request(input in_t req, input logic pinned, input out_t want);
    out_t verdict;
    int   gap;
    if ($urandom_range(0, 19) == 0) in_burst = ~in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    verdict = police_request(req);
    verdicts_due.push_back(pinned ? want : verdict);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      if ($urandom_range(0, 19) == 0) out_burst = ~out_burst;
      out_hold = out_burst ? 0 : $urandom_range(0, 8);
      out_ready <= (out_hold == 0);
    end else if (out_hold != 0) begin
      out_hold = out_hold - 1;
      out_ready <= (out_hold == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_t due;
    if (rst_n && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        bad_verdicts++;
        if (bad_verdicts <= 200)
          $display("%0t: result with none expected: allowed=%0d remaining=%0d retry=%0d",
                   $time, out_data.allowed, out_data.remaining, out_data.retry_after_ms);
      end else begin
        due = verdicts_due.pop_front();
        if (out_data.allowed !== due.allowed || out_data.remaining !== due.remaining ||
            out_data.retry_after_ms !== due.retry_after_ms) begin
          bad_verdicts++;
          if (bad_verdicts <= 200)
            $display("%0t: expected allowed=%0d remaining=%0d retry=%0d, got %0d %0d %0d",
                     $time, due.allowed, due.remaining, due.retry_after_ms,
                     out_data.allowed, out_data.remaining, out_data.retry_after_ms);
        end
      end
    end
  end

  initial begin
    for (int b = 0; b < BUCKETS; b++) begin
      bkt_live[b]   = 1'b0;
      bkt_tokens[b] = '0;
      bkt_stamp[b]  = '0;
    end

    // Reset limits: fresh buckets, repeats, one index on all levels, time at both ends.
    add_row(0, 0, 0, 0, 1, 2, 0, 1, 1, 999, 0);
    add_row(0, 0, 0, 0, 1, 2, 0, 1, 1, 998, 0);
    add_row(0, 0, 0, 5, 5, 5, 0, 1, 1, 997, 0);
    add_row(0, 0, 0, 1023, 1023, 1023, 32'hFFFF_FFFF, 1, 1, 997, 0);
    add_row(0, 0, 0, 1023, 1023, 1023, 0, 1, 1, 994, 0);
    add_row(0, 0, 0, 0, 1, 2, 100, 0, 0, 0, 0);
    add_row(0, 0, 0, 682, 341, 5, 32'hAAAA_AAAA, 0, 0, 0, 0);
    add_row(0, 0, 0, 341, 682, 1018, 32'h5555_5555, 0, 0, 0, 0);
    // One token and no refill: a drained bucket denies, and later levels stay untouched.
    add_row(1, 1, 0, 10, 11, 12, 5, 1, 1, 0, 0);
    add_row(0, 0, 0, 10, 11, 12, 6, 1, 0, 0, 1000);
    add_row(0, 0, 0, 20, 20, 21, 6, 1, 0, 0, 1000);
    add_row(0, 0, 0, 21, 22, 23, 6, 1, 1, 0, 0);
    // Zero capacity denies at once and the retry time follows the rate; the largest capacity grants.
    add_row(1, 0, 7, 30, 31, 32, 0, 1, 0, 0, 142);
    add_row(1, 0, 65535, 50, 51, 52, 0, 1, 0, 0, 0);
    add_row(1, 0, 1, 53, 54, 55, 0, 1, 0, 0, 1000);
    add_row(1, 65535, 65535, 40, 41, 42, 0, 1, 1, 65534, 0);
    add_row(0, 0, 0, 10, 11, 12, 7, 0, 0, 0, 0);
    // Lowered capacity clamps the full buckets on their next use.
    add_row(1, 3, 1, 40, 41, 42, 1, 0, 0, 0, 0);
    add_row(0, 0, 0, 40, 41, 42, 1, 0, 0, 0, 0);
    add_row(0, 0, 0, 40, 41, 42, 1, 0, 0, 0, 0);
    add_row(0, 0, 0, 40, 41, 42, 0, 0, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].set_cfg) set_limits(directed[i].cap, directed[i].rate);
      send_request(directed[i].req, directed[i].pinned, directed[i].want);
    end

    phase_cap[10]  = $urandom_range(1, 65535);
    phase_rate[10] = $urandom_range(1, 65535);
    for (int p = 0; p < 11; p++) begin
      set_limits(TOK_W'(phase_cap[p]), TOK_W'(phase_rate[p]));
      hot_base = IDX_W'($urandom);
      repeat (115) send_request(draw_request(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (bad_verdicts == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
